[hw/rtl/isc_pkg.sv]
// Shared op codes, status codes and cell control type for the indexed stack.
`timescale 1ns / 1ps

package isc_pkg;

	localparam int DEPTH_DEF    = 64;
	localparam int TAG_BITS_DEF = 16;

	localparam logic [2:0] OP_PUSH        = 3'd0;
	localparam logic [2:0] OP_POP         = 3'd1;
	localparam logic [2:0] OP_READ        = 3'd2;
	localparam logic [2:0] OP_ERASE       = 3'd3;
	localparam logic [2:0] OP_ERASE_RANGE = 3'd4;
	localparam logic [2:0] OP_SET_FILL    = 3'd5;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_IGNORED  = 2'd2;

	typedef struct packed {
		logic push;
		logic snap;
		logic shift;
		logic restore;
		logic rd_sel;
	} isc_cell_ctl_t;

endpackage

[hw/rtl/isc_cell.sv]
// One stack cell: entry word and tag, a snapshot copy, and a shift-down path.
`timescale 1ns / 1ps

module isc_cell
	import isc_pkg::*;
#(
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  isc_cell_ctl_t       ctl,
	input  logic [63:0]         push_word,
	input  logic [TAG_BITS-1:0] push_tag_w,
	input  logic [63:0]         next_word,
	input  logic [TAG_BITS-1:0] next_tag,
	output logic [63:0]         cur_word,
	output logic [TAG_BITS-1:0] cur_tag,
	output logic [63:0]         rd_word,
	output logic [TAG_BITS-1:0] rd_tag
);

	logic [63:0]         word_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [63:0]         snap_word_q;
	logic [TAG_BITS-1:0] snap_tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			tag_q  <= '0;
		end else if (ctl.restore) begin
			word_q <= snap_word_q;
			tag_q  <= snap_tag_q;
		end else if (ctl.shift) begin
			word_q <= next_word;
			tag_q  <= next_tag;
		end else if (ctl.push) begin
			word_q <= push_word;
			tag_q  <= push_tag_w;
		end
	end

	// copy taken when an erase starts; entries above the new top come back from it
	always_ff @(posedge clk) begin
		if (ctl.snap) begin
			snap_word_q <= word_q;
			snap_tag_q  <= tag_q;
		end
	end

	assign cur_word = word_q;
	assign cur_tag  = tag_q;
	assign rd_word  = ctl.rd_sel ? word_q : '0;
	assign rd_tag   = ctl.rd_sel ? tag_q : '0;

endmodule

[hw/rtl/indexed_stack_with_compaction_unit.sv]
// Indexed stack with gap-closing erase: control, output register and row of cells.
// Results: push, pop, read, set fill and refused or ignored requests give their result
//   in the cycle after acceptance; an erase gives its result after its last shift step.
// Throughput: one request per cycle unless out_ready stalls the output; an erase moves
//   the cell row down by one neighbor per cycle and holds off new requests until done.
// Reset: arst_n clears every entry, the fill level and the output register at once.
`timescale 1ns / 1ps

module indexed_stack_with_compaction_unit
	import isc_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic signed [6:0]  index,
	input  logic [6:0]         count,
	input  logic [63:0]        push_data,
	input  logic [15:0]        push_tag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        read_data,
	output logic [15:0]        read_tag,
	output logic               read_hit,
	output logic [1:0]         status,
	output logic [6:0]         fill_level
);

	localparam int FW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = ((FW > 7) ? FW : 7) + 2;

	typedef enum logic {S_IDLE, S_SHIFT} state_t;

	state_t              state_q;
	logic [FW-1:0]       fill_q;
	logic [FW-1:0]       newfill_q;
	logic [IW-1:0]       pos_q;
	logic [6:0]          rem_q;
	logic                out_valid_q;
	logic [63:0]         read_data_q;
	logic [15:0]         read_tag_q;
	logic                read_hit_q;
	logic [1:0]          status_q;
	logic [6:0]          fill_level_q;

	logic                accept;
	logic                last;
	logic                res_load;
	logic signed [PW-1:0] fill_x, idx_x, cnt_x, pos_x, ern_x, newfill_x;
	logic                in_fill, rng_ok, is_full, er_go;
	logic [IW-1:0]       pos_i;
	logic [31:0]         tag_wide;
	logic [TAG_BITS-1:0] tag_in;

	logic [FW-1:0]       res_fill;
	logic [1:0]          res_status;
	logic                res_hit;
	logic [63:0]         res_word;
	logic [15:0]         res_tag;
	logic [31:0]         res_fill_w, newfill_w, rd_tag_w;

	isc_cell_ctl_t       ctl [DEPTH];
	logic [63:0]         cur_word [DEPTH];
	logic [TAG_BITS-1:0] cur_tag [DEPTH];
	logic [63:0]         rd_word [DEPTH];
	logic [TAG_BITS-1:0] rd_tag [DEPTH];
	logic [63:0]         rd_or_word;
	logic [TAG_BITS-1:0] rd_or_tag;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign last     = (rem_q == 7'd1);
	assign res_load = ((state_q == S_IDLE) && accept && !er_go) ||
		((state_q == S_SHIFT) && last);

	// index resolution against the current fill
	assign fill_x  = signed'(PW'(fill_q));
	assign idx_x   = PW'(index);
	assign cnt_x   = signed'(PW'(count));
	assign pos_x   = index[6] ? (fill_x + idx_x) : idx_x;
	assign pos_i   = pos_x[IW-1:0];
	assign in_fill = !pos_x[PW-1] && (pos_x < fill_x);
	assign rng_ok  = !pos_x[PW-1] && ((pos_x + cnt_x) <= fill_x);
	assign is_full = (fill_q == FW'(DEPTH));
	assign ern_x   = (op == OP_ERASE) ? PW'(1) : cnt_x;
	assign newfill_x = fill_x - ern_x;
	assign er_go   = accept && (((op == OP_ERASE) && in_fill) ||
		((op == OP_ERASE_RANGE) && (count != 7'd0) && rng_ok));

	assign tag_wide = 32'(push_tag);
	assign tag_in   = tag_wide[TAG_BITS-1:0];

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctl[i].push    = accept && (op == OP_PUSH) && !is_full && (FW'(i) == fill_q);
			ctl[i].snap    = er_go;
			ctl[i].rd_sel  = accept && (op == OP_READ) && in_fill && (IW'(i) == pos_i);
			ctl[i].restore = (state_q == S_SHIFT) && last &&
				(FW'(i) >= newfill_q) && (FW'(i) < fill_q);
			ctl[i].shift   = (state_q == S_SHIFT) && (IW'(i) >= pos_q) &&
				(FW'(i + 1) < fill_q) && !ctl[i].restore;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [63:0]         nxt_word;
		logic [TAG_BITS-1:0] nxt_tag;
		if (g < DEPTH - 1) begin : g_mid
			assign nxt_word = cur_word[g+1];
			assign nxt_tag  = cur_tag[g+1];
		end else begin : g_end
			assign nxt_word = '0;
			assign nxt_tag  = '0;
		end
		isc_cell #(
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[g]),
			.push_word  (push_data),
			.push_tag_w (tag_in),
			.next_word  (nxt_word),
			.next_tag   (nxt_tag),
			.cur_word   (cur_word[g]),
			.cur_tag    (cur_tag[g]),
			.rd_word    (rd_word[g]),
			.rd_tag     (rd_tag[g])
		);
	end

	always_comb begin
		rd_or_word = '0;
		rd_or_tag  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or_word = rd_or_word | rd_word[i];
			rd_or_tag  = rd_or_tag | rd_tag[i];
		end
	end

	assign rd_tag_w = 32'(rd_or_tag);

	always_comb begin
		res_fill   = fill_q;
		res_status = ST_DONE;
		res_hit    = 1'b0;
		res_word   = '0;
		res_tag    = '0;
		case (op)
			OP_PUSH: begin
				if (is_full) res_status = ST_OVERFLOW;
				else         res_fill   = fill_q + FW'(1);
			end
			OP_POP: begin
				if (fill_q != '0) res_fill = fill_q - FW'(1);
			end
			OP_READ: begin
				if (in_fill) begin
					res_hit  = 1'b1;
					res_word = rd_or_word;
					res_tag  = rd_tag_w[15:0];
				end
			end
			OP_ERASE: begin
				if (!in_fill) res_status = ST_IGNORED;
			end
			OP_ERASE_RANGE: begin
				if ((count != 7'd0) && !rng_ok) res_status = ST_IGNORED;
			end
			OP_SET_FILL: begin
				if (cnt_x > PW'(DEPTH)) res_status = ST_OVERFLOW;
				else                    res_fill   = cnt_x[FW-1:0];
			end
			default: ;
		endcase
	end

	assign res_fill_w = 32'(res_fill);
	assign newfill_w  = 32'(newfill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			newfill_q    <= '0;
			pos_q        <= '0;
			rem_q        <= '0;
			out_valid_q  <= 1'b0;
			read_data_q  <= '0;
			read_tag_q   <= '0;
			read_hit_q   <= 1'b0;
			status_q     <= ST_DONE;
			fill_level_q <= '0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (er_go) begin
						state_q   <= S_SHIFT;
						pos_q     <= pos_i;
						rem_q     <= ern_x[6:0];
						newfill_q <= newfill_x[FW-1:0];
					end else if (accept) begin
						fill_q       <= res_fill;
						read_data_q  <= res_word;
						read_tag_q   <= res_tag;
						read_hit_q   <= res_hit;
						status_q     <= res_status;
						fill_level_q <= res_fill_w[6:0];
					end
				end
				S_SHIFT: begin
					rem_q <= rem_q - 7'd1;
					if (last) begin
						state_q      <= S_IDLE;
						fill_q       <= newfill_q;
						read_data_q  <= '0;
						read_tag_q   <= '0;
						read_hit_q   <= 1'b0;
						status_q     <= ST_DONE;
						fill_level_q <= newfill_w[6:0];
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign read_tag   = read_tag_q;
	assign read_hit   = read_hit_q;
	assign status     = status_q;
	assign fill_level = fill_level_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill level above capacity");

	a_erase_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) && last |=> out_valid_q && (state_q == S_IDLE))
		else $error("erase did not finish with a result");

	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == OP_POP) && (fill_q != '0) |=> fill_q == $past(fill_q) - FW'(1))
		else $error("pop did not lower the fill level");

endmodule
